>>> hdl/lis_pkg.sv
// shared constants, types and helper functions for the lis tail-store block
package lis_pkg;

  // tail store capacity, one cell per entry
  localparam int DEPTH = 1024;

  // payload widths fixed by the channel fields
  localparam int VAL_W = 32;
  localparam int LEN_W = 11;

  // internal length counter holds 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fan-in of each node in the append-detect tree
  localparam int TREE_FAN = 32;

  // number of nodes at a given level of the reduction tree (level 0 = leaves)
  function automatic int tree_width(input int lvl);
    int w;
    w = DEPTH;
    for (int i = 0; i < lvl; i++) begin
      w = (w + TREE_FAN - 1) / TREE_FAN;
    end
    return w;
  endfunction

  // registered levels needed to reduce DEPTH leaves to one bit
  function automatic int tree_levels();
    int w;
    int n;
    w = DEPTH;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (w > 1) begin
        w = (w + TREE_FAN - 1) / TREE_FAN;
        n++;
      end
    end
    return n;
  endfunction

  localparam int TREE_LVLS = tree_levels();

  // broadcast from the input side to every cell
  typedef struct packed {
    logic                    accept;
    logic                    last;
    logic signed [VAL_W-1:0] key;
  } cell_bcast_t;

  // item info that travels alongside the tree
  typedef struct packed {
    logic vld;
    logic last;
    logic drop;
  } side_t;

endpackage

>>> hdl/lis_ifs.sv
// valid/ready channel interfaces for the input values and the length results

interface lis_in_if import lis_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface lis_out_if import lis_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] length;
  logic             final_res;
  logic             overflow;

  modport source (output valid, output length, output final_res, output overflow, input ready);
  modport sink (input valid, input length, input final_res, input overflow, output ready);
endinterface

>>> hdl/lis_cell.sv
// one tail cell: holds a tail, compares it to the broadcast key, hands its flag on
module lis_cell import lis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_bcast_t bc_i,
  input  logic        prev_ge_i,
  output logic        ge_o,
  output logic        new_o
);

  logic                    valid_q, valid_d;
  logic signed [VAL_W-1:0] tail_q;
  logic                    wr;

  // an empty cell counts as not below the key, so flags rise once along the row
  assign ge_o  = !valid_q || (tail_q >= bc_i.key);
  // first cell whose flag is set takes the key
  assign wr    = bc_i.accept && ge_o && !prev_ge_i;
  assign new_o = wr && !valid_q;

  // valid bit: set on append, cleared when the sequence closes
  always_comb begin
    valid_d = valid_q;
    if (bc_i.accept && bc_i.last) begin
      valid_d = 1'b0;
    end else if (wr) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // tail payload
  always_ff @(posedge clk_i) begin
    if (wr) begin
      tail_q <= bc_i.key;
    end
  end

endmodule

>>> hdl/lis_or_tree.sv
// registered or-reduction of the per-cell append flags
module lis_or_tree import lis_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEPTH-1:0] leaf_i,
  output logic             any_o
);

  logic [DEPTH-1:0] node_d [TREE_LVLS];
  logic [DEPTH-1:0] node_q [TREE_LVLS];

  // each level ors groups of TREE_FAN bits from the level below
  for (genvar l = 0; l < TREE_LVLS; l++) begin : g_lvl
    localparam int WIn  = tree_width(l);
    localparam int WOut = tree_width(l + 1);
    for (genvar j = 0; j < WOut; j++) begin : g_node
      localparam int Lo = j * TREE_FAN;
      localparam int Hi = ((j + 1) * TREE_FAN < WIn) ? ((j + 1) * TREE_FAN - 1) : (WIn - 1);
      if (l == 0) begin : g_leaf
        assign node_d[l][j] = |leaf_i[Hi:Lo];
      end else begin : g_inner
        assign node_d[l][j] = |node_q[l-1][Hi:Lo];
      end
    end
    if (WOut < DEPTH) begin : g_pad
      assign node_d[l][DEPTH-1:WOut] = '0;
    end
  end

  // level registers advance with the rest of the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < TREE_LVLS; l++) begin
        node_q[l] <= node_d[l];
      end
    end
  end

  assign any_o = node_q[TREE_LVLS-1][0];

endmodule

>>> hdl/lis_length_patience_tails.sv
// top level: row of tail cells, append-detect tree and length/overflow output stage
// each value passes the registered tree levels, then the output register, on its way to a result
// throughput: one value per cycle while the output is not stalled; all cells compare against the key in the same cycle
// the append-detect tree (TREE_FAN-wide nodes, TREE_LVLS levels) and the output register set the latency
// a stalled output holds the whole pipeline, the input side then stops taking values
// reset: asynchronous, active low; clears cell valid bits, length, overflow flag and pipe valids
module lis_length_patience_tails import lis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);

  logic             adv;
  logic             accept;
  cell_bcast_t      bc;
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] new_vec;
  logic             drop;
  logic             grow;

  side_t            side_q [TREE_LVLS];
  side_t            side_fin;

  logic [CNT_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] new_len;
  logic             new_ovf;

  logic             out_vld_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_fin_q;
  logic             out_ovf_q;

  // pipeline moves whenever the output register is free or being taken
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  assign bc.accept = accept;
  assign bc.last   = in_i.last;
  assign bc.key    = in_i.value;

  // row of cells, each sees the flag of its left neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_ge;
    if (i == 0) begin : g_head
      assign prev_ge = 1'b0;
    end else begin : g_body
      assign prev_ge = ge[i-1];
    end
    lis_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bc_i      (bc),
      .prev_ge_i (prev_ge),
      .ge_o      (ge[i]),
      .new_o     (new_vec[i])
    );
  end

  // store full and key above every tail: the value is dropped
  assign drop = !ge[DEPTH-1];

  lis_or_tree u_tree (
    .clk_i  (clk_i),
    .en_i   (adv),
    .leaf_i (new_vec),
    .any_o  (grow)
  );

  // item info alongside the tree levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TREE_LVLS; k++) begin
        side_q[k] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= '{vld: accept, last: in_i.last, drop: drop};
      for (int k = 1; k < TREE_LVLS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_fin = side_q[TREE_LVLS-1];

  // length and sticky overflow, cleared after a closing item
  assign new_len = len_q + CNT_W'(grow);
  assign new_ovf = ovf_q || side_fin.drop;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (adv && side_fin.vld) begin
      if (side_fin.last) begin
        len_d = '0;
        ovf_d = 1'b0;
      end else begin
        len_d = new_len;
        ovf_d = new_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      if (adv) begin
        out_vld_q <= side_fin.vld;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (adv && side_fin.vld) begin
      out_len_q <= LEN_W'(new_len);
      out_fin_q <= side_fin.last;
      out_ovf_q <= new_ovf;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.length    = out_len_q;
  assign out_o.final_res = out_fin_q;
  assign out_o.overflow  = out_ovf_q;

  // cell flags rise at most once along the row
  a_ge_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({ge[DEPTH-2:0], 1'b0} & ~ge) == '0)
    else $error("cell flags not monotonic");

  // at most one cell appends per transfer
  a_one_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(new_vec))
    else $error("more than one cell appended");

  // a dropped value never also appends
  a_drop_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_fin.vld |-> !(side_fin.drop && grow))
    else $error("dropped value also appended");

  // length never passes the store capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(DEPTH))
    else $error("length beyond capacity");

  // a closing item leaves length and overflow cleared
  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && side_fin.vld && side_fin.last) |=> (len_q == '0 && !ovf_q))
    else $error("state not cleared after closing item");

endmodule

>>> tb/tb_lis_length_patience_tails.sv
// self-checking testbench for the longest-increasing-subsequence length block
`timescale 1ns / 1ps

module tb_lis_length_patience_tails import lis_pkg::*; ();

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int ITEMS_PER_PHASE = 20;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_PRINTS      = 40;

  typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SNK_STALLS, PH_BOTH_LIGHT} idle_phase_e;
  typedef enum int {SEQ_WIDE, SEQ_NARROW, SEQ_RISING, SEQ_EXTREME} seq_kind_e;

  // predicts the running subsequence length and checks each length transfer
  class lis_length_tracker;
    typedef struct {
      logic [LEN_W-1:0] length;
      logic             final_res;
      logic             overflow;
    } lis_result_t;

    logic signed [VAL_W-1:0] pile_tops [DEPTH];
    int unsigned             run_len;
    bit                      dropped_seen;
    lis_result_t             lengths_due [$];
    int unsigned             mismatches;
    int unsigned             results_seen;

    // patience step: replace first top not below the value, else append, or mark a drop when the store is full
    function void take_value(logic signed [VAL_W-1:0] v, logic l);
      int unsigned slot;
      int unsigned i;
      lis_result_t res;
      slot = run_len;
      for (i = 0; i < run_len; i++) begin
        if (pile_tops[i] >= v) begin
          slot = i;
          break;
        end
      end
      if (slot < run_len) begin
        pile_tops[slot] = v;
      end else if (run_len < DEPTH) begin
        pile_tops[run_len] = v;
        run_len++;
      end else begin
        dropped_seen = 1'b1;
      end
      res.length    = LEN_W'(run_len);
      res.final_res = l;
      res.overflow  = dropped_seen;
      lengths_due.push_back(res);
      // closing item starts a fresh sequence
      if (l) begin
        run_len      = 0;
        dropped_seen = 1'b0;
      end
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTS) begin
        $display("mismatch at result %0d: %s", results_seen, msg);
      end
      mismatches++;
    endtask

    task match_length(logic [LEN_W-1:0] len, logic fin, logic ovf);
      lis_result_t res;
      if (lengths_due.size() == 0) begin
        report($sformatf("unexpected result length=%0d final=%0b overflow=%0b", len, fin, ovf));
      end else begin
        res = lengths_due.pop_front();
        if (len !== res.length) begin
          report($sformatf("length %0d, want %0d", len, res.length));
        end
        if (fin !== res.final_res) begin
          report($sformatf("final_res %0b, want %0b", fin, res.final_res));
        end
        if (ovf !== res.overflow) begin
          report($sformatf("overflow %0b, want %0b", ovf, res.overflow));
        end
      end
      results_seen++;
    endtask

    function int pending();
      return lengths_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lis_in_if  in_if ();
  lis_out_if out_if ();

  lis_length_patience_tails u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lis_length_tracker tracker = new();
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random backpressure and checking of each transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.match_length(out_if.length, out_if.final_res, out_if.overflow);
    end
    out_if.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("lis_length_patience_tails regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_phase(idle_phase_e ph);
    case (ph)
      PH_STEADY: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PH_SRC_GAPS: begin
        idle_pct  = 77;
        stall_pct = 0;
      end
      PH_SNK_STALLS: begin
        idle_pct  = 0;
        stall_pct = 77;
      end
      default: begin
        idle_pct  = 10;
        stall_pct = 10;
      end
    endcase
  endtask

  // one value transfer, with optional idle cycles ahead of it
  task automatic push_value(logic signed [VAL_W-1:0] v, logic l);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= l;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_value(v, l);
  endtask

  // one closed sequence of random content
  task automatic run_sequence(seq_kind_e kind, int n);
    logic signed [VAL_W-1:0] v;
    int k;
    v = $urandom;
    for (k = 0; k < n; k++) begin
      case (kind)
        SEQ_WIDE:   v = $urandom;
        SEQ_NARROW: v = $urandom_range(0, 8) - 4;
        // mostly rising, with repeats and small dips
        SEQ_RISING: v = v + $urandom_range(0, 40) - 8;
        default: begin
          case ($urandom_range(0, 7))
            0: v = VAL_MIN;
            1: v = VAL_MIN + 1;
            2: v = -1;
            3: v = 0;
            4: v = 1;
            5: v = VAL_MAX - 1;
            6: v = VAL_MAX;
            default: v = $urandom;
          endcase
        end
      endcase
      push_value(v, k == n - 1);
    end
  endtask

  initial begin
    int i;
    int sent;
    int n;
    idle_phase_e ph;

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    in_if.last   <= 1'b0;
    set_phase(PH_STEADY);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-item sequences at the field extremes
    push_value(VAL_MIN, 1'b1);
    push_value(VAL_MAX, 1'b1);
    // equal values never lengthen the run
    push_value(0, 1'b0);
    push_value(0, 1'b0);
    push_value(0, 1'b0);
    push_value(-1, 1'b0);
    push_value(1, 1'b0);
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MAX, 1'b0);
    push_value(VAL_MIN, 1'b1);
    // strictly falling
    push_value(VAL_MAX, 1'b0);
    push_value(5, 1'b0);
    push_value(0, 1'b0);
    push_value(-5, 1'b0);
    push_value(VAL_MIN, 1'b1);
    // strictly rising across the sign boundary
    push_value(VAL_MIN, 1'b0);
    push_value(-1, 1'b0);
    push_value(0, 1'b0);
    push_value(1, 1'b0);
    push_value(VAL_MAX, 1'b1);

    // fill the tail store, then drop appends and still take a replacement
    for (i = 0; i < DEPTH + 1; i++) begin
      push_value(VAL_MIN + i, 1'b0);
    end
    push_value(VAL_MIN + 5, 1'b0);
    push_value(VAL_MAX, 1'b0);
    push_value(-1, 1'b1);
    // overflow flag must be clear again
    push_value(7, 1'b1);

    // random sequences under each idling pattern
    for (int p = 0; p < 4; p++) begin
      ph = idle_phase_e'(p);
      set_phase(ph);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        n = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
        run_sequence(seq_kind_e'($urandom_range(0, 3)), n);
        sent += n;
      end
    end

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TREE_LVLS + 4) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("lis_length_patience_tails regression: pass");
    end else begin
      $display("lis_length_patience_tails regression: fail");
    end
    $finish;
  end

endmodule
